// File: sv/tse_pkg.sv
// Package: shared types, constants and state codes of the topological sort engine.
`default_nettype none
package tse_pkg;

  localparam int unsigned MaxNodesDef = 64;
  localparam int unsigned MaxEdgesDef = 256;

  localparam logic [1:0] StatusOk       = 2'd0;
  localparam logic [1:0] StatusCycle    = 2'd1;
  localparam logic [1:0] StatusOverflow = 2'd2;

  localparam logic ReqAddEdge = 1'b0;
  localparam logic ReqRun     = 1'b1;

  typedef struct packed {
    logic       req_type;
    logic [5:0] edge_from;
    logic [5:0] edge_to;
  } req_t;

  typedef struct packed {
    logic [5:0] node_index;
    logic [1:0] status;
    logic       last;
  } res_t;

  typedef enum logic [3:0] {
    StIdle,
    StClear,
    StCount,
    StSeed,
    StPop,
    StScan,
    StCheck,
    StEmit,
    StFail
  } state_e;

endpackage
`default_nettype wire

// File: sv/tse_edge_mem.sv
// Edge store: source and destination memories with registered read data.
`default_nettype none
module tse_edge_mem #(
  parameter int unsigned MaxEdges = 256,
  parameter int unsigned EdgeAw   = 8
) (
  input  wire logic              clk_i,
  input  wire logic              we_i,
  input  wire logic [EdgeAw-1:0] waddr_i,
  input  wire logic [5:0]        wsrc_i,
  input  wire logic [5:0]        wdst_i,
  input  wire logic [EdgeAw-1:0] raddr_i,
  output logic      [5:0]        rsrc_o,
  output logic      [5:0]        rdst_o
);
  logic [5:0] src_mem [MaxEdges];
  logic [5:0] dst_mem [MaxEdges];

  // Write one edge, read one edge per cycle
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      src_mem[waddr_i] <= wsrc_i;
      dst_mem[waddr_i] <= wdst_i;
    end
    rsrc_o <= src_mem[raddr_i];
    rdst_o <= dst_mem[raddr_i];
  end
endmodule
`default_nettype wire

// File: sv/tse_node_mem.sv
// Node memories: in-degree table, ready FIFO and order buffer.
`default_nettype none
module tse_node_mem #(
  parameter int unsigned MaxNodes = 64,
  parameter int unsigned NodeAw   = 6,
  parameter int unsigned DegW     = 9
) (
  input  wire logic              clk_i,
  input  wire logic              deg_we_i,
  input  wire logic [NodeAw-1:0] deg_waddr_i,
  input  wire logic [DegW-1:0]   deg_wdata_i,
  input  wire logic [NodeAw-1:0] deg_raddr_i,
  output logic      [DegW-1:0]   deg_rdata_o,
  input  wire logic              q_we_i,
  input  wire logic [NodeAw-1:0] q_waddr_i,
  input  wire logic [5:0]        q_wdata_i,
  input  wire logic [NodeAw-1:0] q_raddr_i,
  output logic      [5:0]        q_rdata_o
);
  logic [DegW-1:0] deg_mem [MaxNodes];
  logic [5:0]      q_mem   [MaxNodes];

  // In-degree read-modify-write storage
  always_ff @(posedge clk_i) begin
    if (deg_we_i) deg_mem[deg_waddr_i] <= deg_wdata_i;
    deg_rdata_o <= deg_mem[deg_raddr_i];
  end

  // Ready queue; entries stay after pop, so it doubles as the order buffer
  always_ff @(posedge clk_i) begin
    if (q_we_i) q_mem[q_waddr_i] <= q_wdata_i;
    q_rdata_o <= q_mem[q_raddr_i];
  end
endmodule
`default_nettype wire

// File: sv/topological_sort_engine.sv
// Top level: Kahn topological sort engine with memory-held graph state.
//
// Usage: write node_count (1..MaxNodes; 0 reads as 1, larger saturates)
// through the cfg channel while idle. Send add-edge items (req_type 0), one
// per cycle, each stored in arrival order; past MaxEdges they are dropped
// and an overflow is flagged. A run item (req_type 1) sorts the graph and
// emits node_count results with last on the final one, or a single failure
// result (status 1 cycle, 2 overflow). Each run empties the edge store.
// A run clears the in-degrees, counts them over the edge store, seeds the
// ready queue, then per placed node pops it and scans the edges (each edge
// is a read then a read-modify-write of the in-degree memory) until the
// queue is empty, checks that every node was placed, then emits the results.
// A run after an overflow goes straight to the failure result.
// Edges are accepted one per cycle while idle.
// The input is stalled during a run. A stall on the result channel holds
// the output register and pauses emission; nothing is lost.
// Reset empties the edge store, clears the overflow flag, sets
// node_count to 1; memories need no clearing pass.
`default_nettype none
module topological_sort_engine #(
  parameter int unsigned MaxNodes = tse_pkg::MaxNodesDef,
  parameter int unsigned MaxEdges = tse_pkg::MaxEdgesDef
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            cfg_valid_i,
  output logic                 cfg_ready_o,
  input  wire logic [6:0]      cfg_data_i,
  input  wire logic            in_valid_i,
  output logic                 in_stall_o,
  input  wire tse_pkg::req_t   in_data_i,
  output logic                 out_valid_o,
  input  wire logic            out_stall_i,
  output tse_pkg::res_t        out_data_o
);
  import tse_pkg::*;

  localparam int unsigned NodeAw = (MaxNodes > 1) ? $clog2(MaxNodes) : 1;
  localparam int unsigned EdgeAw = (MaxEdges > 1) ? $clog2(MaxEdges) : 1;
  localparam int unsigned EcW    = $clog2(MaxEdges + 1);
  localparam int unsigned NcW    = $clog2(MaxNodes + 1);
  localparam int unsigned DegW   = EcW;

  state_e state_q, state_d;
  logic [6:0]      ncfg_q;
  logic [NcW-1:0]  n_eff;
  logic [EcW-1:0]  etot_q, etot_d;
  logic            ovf_q, ovf_d;
  logic [EcW-1:0]  eidx_q, eidx_d;    // edge being issued
  logic            phase_q, phase_d;  // 0 issue read, 1 data back
  logic [NcW-1:0]  nidx_q, nidx_d;    // node sweep / emit index
  logic [NcW-1:0]  head_q, head_d, tail_q, tail_d;
  logic [5:0]      cur_q, cur_d;
  logic            fwd_v_q, fwd_v_d;  // last written degree, for forwarding
  logic [NodeAw-1:0] fwd_a_q, fwd_a_d;
  logic [DegW-1:0] fwd_d_q, fwd_d_d;
  logic            ov_q, ov_d;
  res_t            od_q, od_d;

  logic            e_we;
  logic [5:0]      e_src, e_dst;
  logic [EdgeAw-1:0] e_raddr;
  logic            d_we;
  logic [NodeAw-1:0] d_waddr, d_raddr;
  logic [DegW-1:0] d_wdata, d_rdata, deg_cur;
  logic            q_we;
  logic [NodeAw-1:0] q_waddr, q_raddr;
  logic [5:0]      q_wdata, q_rdata;
  logic            edge_ok;
  logic            in_acc, out_free;
  logic            mw_d_we, mw_q_we;
  logic [NodeAw-1:0] mw_d_a;
  logic [DegW-1:0] mw_d_v;
  logic [5:0]      mw_q_v;

  tse_edge_mem #(.MaxEdges(MaxEdges), .EdgeAw(EdgeAw)) u_edges (
    .clk_i, .we_i(e_we), .waddr_i(etot_q[EdgeAw-1:0]),
    .wsrc_i(in_data_i.edge_from), .wdst_i(in_data_i.edge_to),
    .raddr_i(e_raddr), .rsrc_o(e_src), .rdst_o(e_dst));

  tse_node_mem #(.MaxNodes(MaxNodes), .NodeAw(NodeAw), .DegW(DegW)) u_nodes (
    .clk_i, .deg_we_i(mw_d_we), .deg_waddr_i(mw_d_a), .deg_wdata_i(mw_d_v),
    .deg_raddr_i(d_raddr), .deg_rdata_o(d_rdata),
    .q_we_i(mw_q_we), .q_waddr_i(q_waddr), .q_wdata_i(mw_q_v),
    .q_raddr_i(q_raddr), .q_rdata_o(q_rdata));

  // Clamp node count
  always_comb begin
    if (ncfg_q == 7'd0) n_eff = NcW'(1);
    else if ({25'd0, ncfg_q} > MaxNodes) n_eff = NcW'(MaxNodes);
    else n_eff = NcW'(ncfg_q);
  end

  assign in_stall_o  = (state_q != StIdle);
  assign cfg_ready_o = (state_q == StIdle);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_free    = !ov_q || !out_stall_i;
  assign out_valid_o = ov_q;
  assign out_data_o  = od_q;
  assign e_we = in_acc && (in_data_i.req_type == ReqAddEdge) &&
                (etot_q < EcW'(MaxEdges));
  assign e_raddr = eidx_q[EdgeAw-1:0];
  assign edge_ok = ({2'b0, e_src} < 8'(n_eff)) && ({2'b0, e_dst} < 8'(n_eff));
  // Forward a degree written in the cycle of the read
  assign deg_cur = (fwd_v_q && fwd_a_q == e_dst[NodeAw-1:0]) ? fwd_d_q : d_rdata;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle:  if (in_acc && in_data_i.req_type == ReqRun)
                 state_d = ovf_q ? StFail : StClear;
      StClear: if (nidx_q + NcW'(1) == n_eff) state_d = StCount;
      StCount: if (eidx_q == etot_q && !phase_q) state_d = StSeed;
      StSeed:  if (phase_q && nidx_q + NcW'(1) == n_eff) state_d = StPop;
      StPop:   if (head_q == tail_q) state_d = StCheck;
               else if (phase_q) state_d = StScan;
      StScan:  if (eidx_q == etot_q && !phase_q) state_d = StPop;
      StCheck: state_d = (head_q == n_eff) ? StEmit : StFail;
      StEmit:  if (out_free && phase_q && nidx_q + NcW'(1) == n_eff) state_d = StIdle;
      StFail:  if (out_free) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  // Datapath and memory control
  always_comb begin
    etot_d = etot_q; ovf_d = ovf_q; eidx_d = eidx_q; phase_d = phase_q;
    nidx_d = nidx_q; head_d = head_q; tail_d = tail_q; cur_d = cur_q;
    fwd_v_d = 1'b0; fwd_a_d = fwd_a_q; fwd_d_d = fwd_d_q;
    ov_d = ov_q && out_stall_i; od_d = od_q;
    d_we = 1'b0; d_waddr = '0; d_wdata = '0; d_raddr = '0;
    q_we = 1'b0; q_waddr = tail_q[NodeAw-1:0]; q_wdata = '0; q_raddr = '0;
    case (state_q)
      StIdle: begin
        if (in_acc && in_data_i.req_type == ReqAddEdge) begin
          if (e_we) etot_d = etot_q + EcW'(1);
          else ovf_d = 1'b1;
        end
        nidx_d = '0; eidx_d = '0; phase_d = 1'b0; head_d = '0; tail_d = '0;
      end
      StClear: begin
        d_we = 1'b1; d_waddr = nidx_q[NodeAw-1:0];
        nidx_d = (nidx_q + NcW'(1) == n_eff) ? '0 : nidx_q + NcW'(1);
      end
      StCount, StScan: begin
        // Issue edge read, then read the in-degree, then write it back
        if (!phase_q) begin
          if (eidx_q != etot_q) begin
            phase_d = 1'b1;
          end else begin
            eidx_d = '0;
            nidx_d = '0;
          end
        end else begin
          // edge data valid: degree read issued now, written back by the update stage
          phase_d = 1'b0;
          eidx_d = eidx_q + EcW'(1);
        end
        // degree read address follows the edge returned this cycle
        d_raddr = e_dst[NodeAw-1:0];
      end
      StSeed: begin
        d_raddr = nidx_q[NodeAw-1:0];
        if (!phase_q) phase_d = 1'b1;
        else begin
          phase_d = 1'b0;
          if (d_rdata == '0) begin
            q_we = 1'b1; q_wdata = 6'(nidx_q); tail_d = tail_q + NcW'(1);
          end
          nidx_d = nidx_q + NcW'(1);
        end
      end
      StPop: begin
        q_raddr = head_q[NodeAw-1:0];
        if (head_q != tail_q) begin
          if (!phase_q) phase_d = 1'b1;
          else begin
            phase_d = 1'b0; cur_d = q_rdata; head_d = head_q + NcW'(1);
            eidx_d = '0;
          end
        end
        nidx_d = '0;
      end
      StEmit: begin
        q_raddr = nidx_q[NodeAw-1:0];
        if (out_free) begin
          if (!phase_q) phase_d = 1'b1;
          else begin
            phase_d = 1'b0;
            ov_d = 1'b1;
            od_d.node_index = q_rdata;
            od_d.status = StatusOk;
            od_d.last = (nidx_q + NcW'(1) == n_eff);
            nidx_d = nidx_q + NcW'(1);
            if (nidx_q + NcW'(1) == n_eff) begin
              etot_d = '0; ovf_d = 1'b0;
            end
          end
        end
      end
      StFail: begin
        if (out_free) begin
          ov_d = 1'b1;
          od_d.node_index = '0;
          od_d.status = ovf_q ? StatusOverflow : StatusCycle;
          od_d.last = 1'b1;
          etot_d = '0; ovf_d = 1'b0;
        end
      end
      default: ;
    endcase
  end

  // Degree update pipeline: edge data (cycle A) -> degree data (cycle B)
  logic            upd_v_q;
  logic [5:0]      upd_d_q;
  logic            upd_cnt_q;
  logic [EcW-1:0]  unused_e;
  assign unused_e = '0;

  // Stage register holds the destination whose degree read is in flight
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upd_v_q <= 1'b0;
    end else begin
      upd_v_q <= ((state_q == StCount) || (state_q == StScan)) && phase_q && (
                   (state_q == StCount) ? edge_ok :
                   (e_src == cur_q && {2'b0, e_dst} < 8'(n_eff)));
    end
  end

  always_ff @(posedge clk_i) begin
    upd_d_q   <= e_dst;
    upd_cnt_q <= (state_q == StCount);
  end

  // Write the modified degree and enqueue a node that reaches zero
  logic [DegW-1:0] deg_old;
  logic            deg_fwd;
  assign deg_fwd = fwd_v_q && fwd_a_q == upd_d_q[NodeAw-1:0];
  assign deg_old = deg_fwd ? fwd_d_q : d_rdata;

  logic            w_we, w_enq;
  logic [DegW-1:0] w_val;
  always_comb begin
    w_we = 1'b0; w_enq = 1'b0; w_val = deg_old;
    if (upd_v_q) begin
      if (upd_cnt_q) begin
        w_we = 1'b1; w_val = deg_old + DegW'(1);
      end else if (deg_old != '0) begin
        w_we = 1'b1; w_val = deg_old - DegW'(1);
        w_enq = (w_val == '0) && (tail_q < NcW'(MaxNodes));
      end
    end
  end

  // Registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle; ncfg_q <= 7'd1; etot_q <= '0; ovf_q <= 1'b0;
      eidx_q <= '0; phase_q <= 1'b0; nidx_q <= '0; head_q <= '0; tail_q <= '0;
      cur_q <= '0; fwd_v_q <= 1'b0; fwd_a_q <= '0; fwd_d_q <= '0; ov_q <= 1'b0;
    end else begin
      state_q <= state_d; etot_q <= etot_d; ovf_q <= ovf_d;
      eidx_q <= eidx_d; phase_q <= phase_d; nidx_q <= nidx_d; head_q <= head_d;
      tail_q <= (w_enq) ? tail_q + NcW'(1) : tail_d;
      cur_q <= cur_d; ov_q <= ov_d;
      fwd_v_q <= w_we; fwd_a_q <= upd_d_q[NodeAw-1:0]; fwd_d_q <= w_val;
      if (cfg_valid_i && cfg_ready_o) ncfg_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i) od_q <= od_d;

  // Memory port muxing for the update write-back and the queue push
  always_comb begin
    mw_d_we = d_we || w_we;
    mw_d_a  = w_we ? upd_d_q[NodeAw-1:0] : d_waddr;
    mw_d_v  = w_we ? w_val : d_wdata;
    mw_q_we = q_we || w_enq;
    mw_q_v  = w_enq ? upd_d_q : q_wdata;
  end

  logic unused_ok;
  assign unused_ok = ^{deg_cur, unused_e, fwd_v_d, fwd_a_d, fwd_d_d};

  // Assertions
  a_stall_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != StIdle) |-> in_stall_o) else $error("input taken during run");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(out_data_o)))
    else $error("stalled result changed");
  a_queue_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    head_q <= tail_q) else $error("queue head passed tail");
  a_cfg_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_ready_o |-> (state_q == StIdle)) else $error("config while busy");
endmodule
`default_nettype wire
